/* rtl/ldfs_pkg.sv */
`default_nettype none
package ldfs_pkg;

  // Chain geometry.
  localparam int CHIPS         = 4;
  localparam int REGS_PER_CHIP = 16;
  localparam int CHIP_W        = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int SHADOW_DEPTH  = CHIPS * REGS_PER_CHIP;
  localparam int SHADOW_AW     = $clog2(SHADOW_DEPTH);

  // Operation queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Division by ten through a reciprocal: q = (n * 0xCCCCCCCD) >> 35.
  localparam logic [31:0] DIGIT_RECIP = 32'hCCCC_CCCD;
  localparam int          DIGIT_SHIFT = 35;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_DISPLAY = 1'b1;

  // One register write for the whole chain.
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic [2:0] chip;
    logic       last;
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_EMIT
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_e;

  // Seven-segment code of one decimal digit.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h27;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

/* rtl/led_driver_chain_frame_sequencer_core.sv */
`default_nettype none
// Frame sequencer for a daisy chain of LED driver chips. It keeps a shadow copy of all
// 16 registers of every chip (zero after reset, no clearing pass: per-entry written
// flags stand in for the reset value). A write command (command 0) stores one register
// for one chip and sends one address/data frame per chip, chain position 0 first, with
// latch_after set on the last chip's frame. A display command (command 1) shows number
// in decimal: scan_limit+1 digits, least significant first, each a segment-coded write
// to addresses scan_limit+1 down to 1. The last frame of each item carries last. The
// back end stores each register write into the shadow RAM, then makes the first
// registered shadow read, and sends one frame per cycle while the output is not
// stalled. Digit extraction in the front end (a division state and an emit state
// per digit) runs ahead through a four-entry queue. The scan_limit register is
// written on its own channel and must only change while the block is idle.
module led_driver_chain_frame_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_scan_limit_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [2:0]  chip_index_i,
  input  wire logic [3:0]  reg_address_i,
  input  wire logic [7:0]  reg_data_i,
  input  wire logic [31:0] number_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       frame_address_o,
  output logic [7:0]       frame_data_o,
  output logic             latch_after_o,
  output logic             last_o
);
  import ldfs_pkg::*;

  logic [2:0] scan_limit_q;
  logic       q_push_valid, q_push_ready;
  op_t        q_push_op;
  logic       q_pop_valid, q_pop_ready;
  op_t        q_pop_op;

  // Configuration register, one transfer per cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= 3'd7;
    end else if (cfg_valid_i) begin
      scan_limit_q <= cfg_scan_limit_i;
    end
  end

  ldfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scan_limit_i  (scan_limit_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .chip_index_i  (chip_index_i),
    .reg_address_i (reg_address_i),
    .reg_data_i    (reg_data_i),
    .number_i      (number_i),
    .push_valid_o  (q_push_valid),
    .push_ready_i  (q_push_ready),
    .push_op_o     (q_push_op)
  );

  ldfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_op_i    (q_push_op),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_op_o     (q_pop_op)
  );

  ldfs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (q_pop_valid),
    .pop_ready_o     (q_pop_ready),
    .pop_op_i        (q_pop_op),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_address_o (frame_address_o),
    .frame_data_o    (frame_data_o),
    .latch_after_o   (latch_after_o),
    .last_o          (last_o)
  );

  // A stalled frame keeps its valid and its contents until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o &&
      $stable({frame_address_o, frame_data_o, latch_after_o, last_o})))
    else $error("stalled frame changed before its transfer");

  // The final frame of an item always closes a register write with the load strobe.
  a_last_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> latch_after_o)
    else $error("last frame without load strobe");

  // Display digits never target address zero.
  a_display_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_DISPLAY) |=> ##1
      (!q_push_valid || q_push_op.addr != 4'd0))
    else $error("display digit written to address zero");

endmodule
`default_nettype wire

/* rtl/ldfs_ram.sv */
`default_nettype none
module ldfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/ldfs_front.sv */
`default_nettype none
module ldfs_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     scan_limit_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           command_i,
  input  wire logic [2:0]     chip_index_i,
  input  wire logic [3:0]     reg_address_i,
  input  wire logic [7:0]     reg_data_i,
  input  wire logic [31:0]    number_i,
  output logic                push_valid_o,
  input  wire logic           push_ready_i,
  output ldfs_pkg::op_t       push_op_o
);
  import ldfs_pkg::*;

  front_state_e state_q, state_d;
  logic [31:0]  num_q, num_d;
  logic [31:0]  quo_q, quo_d;
  logic [2:0]   k_q, k_d;
  logic [2:0]   chip_q, chip_d;
  logic [63:0]  prod;
  logic [31:0]  times_ten;
  logic [31:0]  rem;

  // Quotient by ten through the reciprocal, remainder by shift and add.
  assign prod      = 64'(num_q) * 64'(DIGIT_RECIP);
  assign times_ten = (quo_q << 3) + (quo_q << 1);
  assign rem       = num_q - times_ten;

  // Command decode and digit sequencing.
  always_comb begin
    state_d      = state_q;
    num_d        = num_q;
    quo_d        = quo_q;
    k_d          = k_q;
    chip_d       = chip_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    push_op_o    = '{addr: reg_address_i, data: reg_data_i, chip: chip_index_i, last: 1'b1};
    case (state_q)
      F_IDLE: begin
        in_ready_o = push_ready_i;
        if (in_valid_i && push_ready_i) begin
          if (command_i == CMD_WRITE) begin
            push_valid_o = 1'b1;
          end else begin
            num_d   = number_i;
            k_d     = 3'd0;
            chip_d  = chip_index_i;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        quo_d   = 32'(prod >> DIGIT_SHIFT);
        state_d = F_EMIT;
      end
      F_EMIT: begin
        push_valid_o = 1'b1;
        push_op_o    = '{addr: 4'(scan_limit_i) + 4'd1 - 4'(k_q),
                         data: seg_code(rem[3:0]),
                         chip: chip_q,
                         last: (k_q == scan_limit_i)};
        if (push_ready_i) begin
          num_d = quo_q;
          k_d   = k_q + 3'd1;
          if (k_q == scan_limit_i) begin
            state_d = F_IDLE;
          end else begin
            state_d = F_DIV;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    k_q    <= k_d;
    chip_q <= chip_d;
  end

endmodule
`default_nettype wire

/* rtl/ldfs_queue.sv */
`default_nettype none
module ldfs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire ldfs_pkg::op_t  push_op_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output ldfs_pkg::op_t       pop_op_o
);
  import ldfs_pkg::*;

  op_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_op_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/ldfs_back.sv */
`default_nettype none
module ldfs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire ldfs_pkg::op_t  pop_op_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [3:0]          frame_address_o,
  output logic [7:0]          frame_data_o,
  output logic                latch_after_o,
  output logic                last_o
);
  import ldfs_pkg::*;

  back_state_e           state_q, state_d;
  op_t                   op_q, op_d;
  logic [CHIP_W-1:0]     chip_cnt_q, chip_cnt_d;
  logic [SHADOW_DEPTH-1:0] vld_q;
  logic                  rd_vld_q;
  logic                  we, re;
  logic [SHADOW_AW-1:0]  waddr, raddr;
  logic [7:0]            rdata;
  logic                  out_free, load;
  logic                  last_chip, in_range;
  logic                  out_valid_q;
  logic [3:0]            addr_q;
  logic [7:0]            data_q;
  logic                  latch_q, last_q;

  function automatic logic [CHIP_W-1:0] pop_pick_chip(input logic [2:0] chip);
    return chip[CHIP_W-1:0];
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_chip = (chip_cnt_q == CHIP_W'(CHIPS - 1));
  assign in_range  = ({1'b0, pop_op_i.chip} < 4'(CHIPS));
  assign waddr     = SHADOW_AW'({pop_pick_chip(pop_op_i.chip), pop_op_i.addr});

  // Sequencer: store the write, then read each chip's copy in chain order.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    chip_cnt_d  = chip_cnt_q;
    pop_ready_o = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    load        = 1'b0;
    raddr       = SHADOW_AW'({chip_cnt_q, op_q.addr});
    case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          op_d       = pop_op_i;
          we         = in_range;
          chip_cnt_d = '0;
          state_d    = B_READ;
        end
      end
      B_READ: begin
        re      = 1'b1;
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (last_chip) begin
            state_d = B_IDLE;
          end else begin
            chip_cnt_d = chip_cnt_q + 1'b1;
            re         = 1'b1;
            raddr      = SHADOW_AW'({chip_cnt_d, op_q.addr});
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  ldfs_ram #(
    .Width (8),
    .Depth (SHADOW_DEPTH)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (pop_op_i.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state, written flags and the output register's valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; an entry never written reads as zero.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    chip_cnt_q <= chip_cnt_d;
    if (re) begin
      rd_vld_q <= vld_q[raddr];
    end
    if (load) begin
      addr_q  <= op_q.addr;
      data_q  <= rd_vld_q ? rdata : 8'h00;
      latch_q <= last_chip;
      last_q  <= last_chip && op_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = addr_q;
  assign frame_data_o    = data_q;
  assign latch_after_o   = latch_q;
  assign last_o          = last_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ldfs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_AFTER    = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 52;

  // Segment codes of the digits 9 down to 0, digit d at bits [8*d +: 8].
  localparam logic [79:0] SEG_TABLE = {8'h6F, 8'h7F, 8'h27, 8'h7D, 8'h6D,
                                       8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef struct packed {
    logic        command;
    logic [2:0]  chip;
    logic [3:0]  addr;
    logic [7:0]  data;
    logic [31:0] number;
  } command_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       latch;
    logic       last;
  } frame_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       cfg_valid      = 1'b0;
  logic [2:0] cfg_scan_limit = '0;
  logic       in_valid       = 1'b0;
  command_t   cur_item       = '0;
  logic       out_ready      = 1'b0;

  wire logic        cfg_ready_o;
  wire logic        in_ready_o;
  wire logic        out_valid_o;
  wire logic [3:0]  frame_address_o;
  wire logic [7:0]  frame_data_o;
  wire logic        latch_after_o;
  wire logic        last_o;

  // Commands waiting for the driver, and frames the chain should see next.
  command_t command_queue[$];
  frame_t   expected_frames[$];

  // Mirror of the chip registers and of the scan limit.
  logic [7:0] shadow_mirror [CHIPS][REGS_PER_CHIP];
  logic [2:0] scan_mirror;

  int errors          = 0;
  int items_accepted  = 0;
  int frames_checked  = 0;
  int settings_used   = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int ready_mode      = 0;
  int mode_left       = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  led_driver_chain_frame_sequencer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_scan_limit_i (cfg_scan_limit),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (cur_item.command),
    .chip_index_i     (cur_item.chip),
    .reg_address_i    (cur_item.addr),
    .reg_data_i       (cur_item.data),
    .number_i         (cur_item.number),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .frame_address_o  (frame_address_o),
    .frame_data_o     (frame_data_o),
    .latch_after_o    (latch_after_o),
    .last_o           (last_o)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stores one register for one chip and queues the frames for the whole chain.
  task automatic queue_chain_write(input logic [2:0] chip, input logic [3:0] addr,
                                   input logic [7:0] data, input bit closes_item);
    frame_t f;
    if (int'(chip) < CHIPS) shadow_mirror[chip][addr] = data;
    for (int c = 0; c < CHIPS; c++) begin
      f.addr  = addr;
      f.data  = shadow_mirror[c][addr];
      f.latch = (c == CHIPS - 1);
      f.last  = closes_item && (c == CHIPS - 1);
      expected_frames.push_back(f);
    end
  endtask

  // Works out every frame that one accepted command causes.
  task automatic predict_command(input command_t item);
    logic [31:0] rest;
    int          digit;
    int          top;
    if (item.command == CMD_WRITE) begin
      queue_chain_write(item.chip, item.addr, item.data, 1'b1);
    end else begin
      rest = item.number;
      top  = int'(scan_mirror);
      for (int k = 0; k <= top; k++) begin
        digit = int'(rest % 10);
        rest  = rest / 10;
        queue_chain_write(item.chip, 4'(top + 1 - k), SEG_TABLE[digit*8 +: 8], k == top);
      end
    end
  endtask

  task automatic queue_command(input logic command, input logic [2:0] chip,
                               input logic [3:0] addr, input logic [7:0] data,
                               input logic [31:0] number);
    command_t c;
    c.command = command;
    c.chip    = chip;
    c.addr    = addr;
    c.data    = data;
    c.number  = number;
    command_queue.push_back(c);
  endtask

  // Numbers that stress digit boundaries as well as plain random values.
  function automatic logic [31:0] pick_number();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 3))
      0: p = $urandom;
      1: p = $urandom_range(0, 999);
      2: begin
        repeat ($urandom_range(1, 9)) p = p * 10;
        p = p - $urandom_range(0, 1);
      end
      default: p = 32'hFFFF_FFFF - $urandom_range(0, 5);
    endcase
    return p;
  endfunction

  // Random command; one in eight targets a position past the end of the chain.
  function automatic command_t random_command();
    command_t c;
    c.command = ($urandom_range(0, 1) == 1) ? CMD_DISPLAY : CMD_WRITE;
    if ($urandom_range(0, 7) == 0) c.chip = 3'($urandom_range(CHIPS, 7));
    else c.chip = 3'($urandom_range(0, CHIPS - 1));
    c.addr   = 4'($urandom);
    c.data   = 8'($urandom);
    c.number = pick_number();
    return c;
  endfunction

  // Scan limit write on the configuration channel; the block is idle here.
  task automatic write_scan_limit(input logic [2:0] value);
    @(posedge clk_i);
    cfg_valid      <= 1'b1;
    cfg_scan_limit <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scan_mirror = value;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every command went in and every frame came out, then settles.
  task automatic wait_idle();
    while (command_queue.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    end
  endtask

  // Command driver: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_command(cur_item);
        items_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left == 0 && command_queue.size() != 0) begin
          cur_item <= command_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Frame receiver backpressure, with one long hold-off once traffic is flowing.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && items_accepted >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // Frame monitor: each transfer is compared with the oldest expected frame.
  always @(posedge clk_i) begin : frame_check
    frame_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual addr %0h data %0h",
                 $realtime, frame_address_o, frame_data_o);
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_address", want.addr, frame_address_o);
        check_field("frame_data", want.data, frame_data_o);
        check_field("latch_after", want.latch, latch_after_o);
        check_field("last", want.last, last_o);
        frames_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Test sequence: directed commands under three settings, then random phases.
  initial begin
    for (int c = 0; c < CHIPS; c++)
      for (int r = 0; r < REGS_PER_CHIP; r++) shadow_mirror[c][r] = 8'h00;
    scan_mirror = 3'd7;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes and chip positions past the chain at the reset scan limit.
    queue_command(CMD_WRITE, 3'd0, 4'd0, 8'h00, 32'h0);
    queue_command(CMD_WRITE, 3'd3, 4'd15, 8'hFF, 32'hFFFF_FFFF);
    queue_command(CMD_WRITE, 3'd7, 4'd5, 8'hAA, 32'h0);
    queue_command(CMD_WRITE, 3'd4, 4'd9, 8'h55, 32'h0);
    queue_command(CMD_WRITE, 3'd1, 4'd8, 8'h81, 32'h0);
    queue_command(CMD_WRITE, 3'd2, 4'd3, 8'h7E, 32'h0);
    queue_command(CMD_DISPLAY, 3'd0, 4'd15, 8'hFF, 32'd0);
    queue_command(CMD_DISPLAY, 3'd3, 4'd0, 8'h00, 32'hFFFF_FFFF);
    queue_command(CMD_DISPLAY, 3'd7, 4'd6, 8'h3C, 32'd12345678);
    queue_command(CMD_DISPLAY, 3'd2, 4'd9, 8'hC3, 32'd98765432);
    queue_command(CMD_DISPLAY, 3'd1, 4'd1, 8'h5A, 32'd10);
    queue_command(CMD_WRITE, 3'd0, 4'd1, 8'h12, 32'd7);
    wait_idle();

    // One digit only: everything above the lowest digit is dropped.
    write_scan_limit(3'd0);
    queue_command(CMD_DISPLAY, 3'd1, 4'd2, 8'h01, 32'd9);
    queue_command(CMD_DISPLAY, 3'd5, 4'd7, 8'hFE, 32'hFFFF_FFFF);
    queue_command(CMD_WRITE, 3'd3, 4'd1, 8'hC3, 32'h0);
    queue_command(CMD_DISPLAY, 3'd0, 4'd11, 8'h80, 32'd4294967290);
    wait_idle();

    write_scan_limit(3'd3);
    queue_command(CMD_DISPLAY, 3'd2, 4'd4, 8'h44, 32'd1234567);
    queue_command(CMD_DISPLAY, 3'd3, 4'd12, 8'h99, 32'd999);
    queue_command(CMD_WRITE, 3'd2, 4'd4, 8'h00, 32'h0);
    queue_command(CMD_WRITE, 3'd1, 4'd15, 8'h01, 32'h0);
    wait_idle();

    // Random phases at both extremes and two other scan limits.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_scan_limit(3'd7);
        1:       write_scan_limit(3'd0);
        2:       write_scan_limit(3'd5);
        default: write_scan_limit(3'($urandom_range(1, 6)));
      endcase
      repeat (PHASE_ITEMS) command_queue.push_back(random_command());
      wait_idle();
    end

    if (expected_frames.size() != 0) begin
      errors++;
      $display("%0t: %0d frames never arrived", $realtime, expected_frames.size());
    end
    $display("Ran %0d commands and checked %0d frames under %0d scan limit writes,",
             items_accepted, frames_checked, settings_used);
    $display("with bursty input, varied output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
